@@ hw/rtl/tbi_pkg.sv @@
package tbi_pkg;

  localparam int unsigned ValW    = 32;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned StatW   = 2;
  localparam int unsigned WeightW = 33;

  typedef enum logic [0:0] {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    STAT_OK    = 2'd0,
    STAT_XCLMP = 2'd1,
    STAT_YCLMP = 2'd2,
    STAT_ZERO  = 2'd3
  } status_t;

  typedef struct packed {
    cmd_t                    cmd;
    logic [IdxW-1:0]         row_index;
    logic [IdxW-1:0]         col_index;
    logic signed [ValW-1:0]  entry_value;
    logic signed [ValW-1:0]  query_x;
    logic signed [ValW-1:0]  query_y;
  } in_item_t;

  typedef struct packed {
    logic signed [ValW-1:0]  interp_value;
    status_t                 status;
  } out_item_t;

  // Handshake between the sequencer and a bit-serial arithmetic unit.
  typedef struct packed {
    logic start;
    logic done;
  } unit_ctl_t;

endpackage

@@ hw/rtl/tbi_if.sv @@
interface tbi_in_if;
  logic               valid;
  logic               ready;
  tbi_pkg::in_item_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface tbi_out_if;
  logic               valid;
  logic               ready;
  tbi_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ hw/rtl/tbi_div.sv @@
// Restoring divider: one quotient bit per cycle. num and den are unsigned with
// num < den; the quotient has 32 fraction bits.
module tbi_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] num,
  input  logic [32:0] den,
  output logic        done,
  output logic [31:0] quot
);
  import tbi_pkg::*;

  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [31:0] q_r, q_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] sh;

  always_comb begin
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh       = {rem_r[32:0], 1'b0};
    if (start) begin
      rem_nxt  = {1'b0, num};
      q_nxt    = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = sh - {1'b0, den_r};
        q_nxt   = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt   = {q_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    if (start) den_r <= den;
  end

  assign done = done_r;
  assign quot = q_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done not a pulse");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !done_nxt) else $error("done without busy");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r < 6'd32) else $error("divider count overrun");
endmodule

@@ hw/rtl/tbi_mul.sv @@
// Shift-add multiplier: mag (33 bits) times weight (33 bits), one weight bit
// per cycle, returning the product shifted right by 32.
module tbi_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [32:0] mag,
  input  logic [32:0] wgt,
  output logic        done,
  output logic [32:0] prod
);
  import tbi_pkg::*;

  logic [65:0] acc_r, acc_nxt;
  logic [32:0] mag_r;
  logic [32:0] w_r, w_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // Accumulate from the top weight bit down: acc = acc*2 + mag*bit.
  always_comb begin
    acc_nxt  = acc_r;
    w_nxt    = w_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      acc_nxt  = '0;
      w_nxt    = wgt;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      acc_nxt = {acc_r[64:0], 1'b0} + (w_r[32] ? {33'd0, mag_r} : 66'd0);
      w_nxt   = {w_r[31:0], 1'b0};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd32) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    w_r   <= w_nxt;
    if (start) mag_r <= mag;
  end

  assign done = done_r;
  assign prod = acc_r[64:32];

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("multiplier done not a pulse");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r <= 6'd32) else $error("multiplier count overrun");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r) else $error("multiplier busy after done");
endmodule

@@ hw/rtl/table_bilinear_interpolator_core.sv @@
// Load: no result; the core stays idle, so the next item can be accepted in the next cycle.
// Query: serial header walks over the single table read port, four corner reads, up to two
// divisions and three multiplications (skipped for a zero-width interval) build the result.
// One item is in work at a time: in_ch.ready stays low until the result has been taken.
// Reset (synchronous, rst_n low) returns the sequencer to idle and drops any
// pending result; table contents are undefined until written.
module table_bilinear_interpolator_core #(
  parameter int unsigned ROW_COUNT = 32,
  parameter int unsigned COL_COUNT = 32
) (
  input  logic clk,
  input  logic rst_n,
  tbi_in_if.sink    in_ch,
  tbi_out_if.source out_ch
);
  import tbi_pkg::*;

  localparam int unsigned RW = $clog2(ROW_COUNT);
  localparam int unsigned CW = $clog2(COL_COUNT);
  localparam int unsigned AW = RW + CW;
  localparam int unsigned Depth = ROW_COUNT * COL_COUNT;

  typedef enum logic [13:0] {
    S_IDLE  = 14'b00000000000001,
    S_XRD   = 14'b00000000000010,
    S_XCHK  = 14'b00000000000100,
    S_YRD   = 14'b00000000001000,
    S_YCHK  = 14'b00000000010000,
    S_CRD   = 14'b00000000100000,
    S_CWAIT = 14'b00000001000000,
    S_DIVX  = 14'b00000010000000,
    S_DIVY  = 14'b00000100000000,
    S_MUL1  = 14'b00001000000000,
    S_MUL2  = 14'b00010000000000,
    S_MUL3  = 14'b00100000000000,
    S_DONE  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  // Table memory with registered read.
  logic signed [ValW-1:0] mem [Depth];
  logic [AW-1:0]          rd_addr;
  logic signed [ValW-1:0] rd_data_r;
  logic                   wr_en;
  logic [AW-1:0]          wr_addr;

  logic signed [ValW-1:0] qx_r, qy_r;
  logic [8:0]             idx_r;          // header walk index, wide for 256
  logic [8:0]             ix_r, iy_r;
  logic                   cx_r, cy_r;
  logic signed [ValW-1:0] prev_r;          // previous header sample
  logic signed [ValW-1:0] h1st_r;          // first header sample
  logic signed [ValW-1:0] h2nd_r;          // second header sample
  logic                   found_r;
  logic signed [ValW-1:0] x0_r, x1_r, y0_r, y1_r;
  logic signed [ValW-1:0] c00_r, c01_r, c10_r, c11_r;
  logic [1:0]             csel_r;
  logic [32:0]            fx_r, fy_r;
  logic signed [33:0]     r1_r, r2_r;
  logic signed [ValW-1:0] res_r;
  status_t                stat_r;

  logic accept;
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);

  // Write port.
  assign wr_en   = accept && (in_ch.payload.cmd == CMD_LOAD)
                   && (32'(in_ch.payload.row_index) < ROW_COUNT)
                   && (32'(in_ch.payload.col_index) < COL_COUNT);
  assign wr_addr = AW'(32'(in_ch.payload.row_index) * COL_COUNT
                       + 32'(in_ch.payload.col_index));

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= in_ch.payload.entry_value;
    rd_data_r <= mem[rd_addr];
  end

  // Read address by phase.
  always_comb begin
    rd_addr = '0;
    unique case (state_r)
      S_XRD:  rd_addr = AW'(idx_r);
      S_YRD:  rd_addr = AW'(32'(idx_r) * COL_COUNT);
      S_CRD:  begin
        unique case (csel_r)
          2'd0: rd_addr = AW'(32'(iy_r) * COL_COUNT + 32'(ix_r));
          2'd1: rd_addr = AW'(32'(iy_r) * COL_COUNT + 32'(ix_r) + 1);
          2'd2: rd_addr = AW'((32'(iy_r) + 1) * COL_COUNT + 32'(ix_r));
          default: rd_addr = AW'((32'(iy_r) + 1) * COL_COUNT + 32'(ix_r) + 1);
        endcase
      end
      default: rd_addr = '0;
    endcase
  end

  // Weight operand preparation.
  logic [32:0] dnum, dden;
  logic signed [32:0] wn, wd, wn2, wd2;
  logic wfull;
  logic signed [ValW-1:0] wc, wh0, wh1;
  always_comb begin
    wc  = (state_r == S_DIVX || state_r == S_CWAIT) ? qx_r : qy_r;
    wh0 = (state_r == S_DIVX || state_r == S_CWAIT) ? x0_r : y0_r;
    wh1 = (state_r == S_DIVX || state_r == S_CWAIT) ? x1_r : y1_r;
    wn  = 33'(wc) - 33'(wh0);
    wd  = 33'(wh1) - 33'(wh0);
    wn2 = wd[32] ? -wn : wn;
    wd2 = wd[32] ? -wd : wd;
    if (wn2[32]) wn2 = '0;
    if (wn2 > wd2) wn2 = wd2;
    wfull = (wn2 == wd2);
    dnum  = wn2;
    dden  = wd2;
  end

  // Arithmetic units.
  logic               div_start, div_done, mul_start, mul_done;
  logic [31:0]        quot;
  logic [32:0]        mul_mag, mul_w, prod;
  logic signed [33:0] la, lb, ld;

  tbi_div u_div (.clk, .rst_n, .start(div_start), .num(dnum), .den(dden),
                 .done(div_done), .quot(quot));
  tbi_mul u_mul (.clk, .rst_n, .start(mul_start), .mag(mul_mag), .wgt(mul_w),
                 .done(mul_done), .prod(prod));

  always_comb begin
    unique case (state_r)
      S_MUL1:  begin la = 34'(c00_r); lb = 34'(c01_r); end
      S_MUL2:  begin la = 34'(c10_r); lb = 34'(c11_r); end
      default: begin la = r1_r;       lb = r2_r;       end
    endcase
    ld      = lb - la;
    mul_mag = ld[33] ? 33'(-ld) : 33'(ld);
    mul_w   = (state_r == S_MUL3) ? fy_r : fx_r;
  end

  logic               fstart_r;    // first cycle in a unit state
  logic signed [33:0] lres;
  assign lres = ld[33] ? la - 34'(prod) : la + 34'(prod);

  logic div_go;
  assign div_go    = fstart_r && !wfull && (state_r == S_DIVX || state_r == S_DIVY);
  assign div_start = div_go;
  assign mul_start = fstart_r && (state_r == S_MUL1 || state_r == S_MUL2
                                  || state_r == S_MUL3);

  logic hit;
  logic signed [ValW-1:0] cur;
  assign cur = rd_data_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (accept && in_ch.payload.cmd == CMD_QUERY) state_nxt = S_XRD;
      S_XRD:   state_nxt = S_XCHK;
      S_XCHK:  state_nxt = S_XRD;
      S_YRD:   state_nxt = S_YCHK;
      S_YCHK:  state_nxt = S_YRD;
      S_CRD:   state_nxt = S_CWAIT;
      S_CWAIT: state_nxt = S_CRD;
      S_DIVX:  state_nxt = S_DIVX;
      S_DIVY:  state_nxt = S_DIVY;
      S_MUL1:  state_nxt = S_MUL1;
      S_MUL2:  state_nxt = S_MUL2;
      S_MUL3:  state_nxt = S_MUL3;
      S_DONE:  state_nxt = S_OUT;
      S_OUT:   if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  logic signed [ValW-1:0] qc;
  logic signed [ValW-1:0] h2nd;
  logic [8:0] hcount;
  assign qc     = (state_r == S_XCHK) ? qx_r : qy_r;
  assign h2nd   = (idx_r == 9'd2) ? cur : h2nd_r;
  assign hcount = (state_r == S_XCHK) ? 9'(COL_COUNT) : 9'(ROW_COUNT);
  assign hit    = (prev_r <= qc) && (qc <= cur);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fstart_r <= 1'b0;
    end else begin
      fstart_r <= 1'b0;
      unique case (state_r)
        S_IDLE: if (accept && in_ch.payload.cmd == CMD_QUERY) begin
          state_r <= S_XRD;
          qx_r    <= in_ch.payload.query_x;
          qy_r    <= in_ch.payload.query_y;
          idx_r   <= 9'd1;
          found_r <= 1'b0;
        end
        S_XRD, S_YRD: state_r <= state_nxt;
        S_XCHK, S_YCHK: begin
          // Samples at idx 1 starts the walk; later ones test [prev, cur].
          if (idx_r == 9'd1) h1st_r <= cur;
          if (idx_r == 9'd2) h2nd_r <= cur;
          if (idx_r > 9'd1 && !found_r && hit) begin
            found_r <= 1'b1;
            if (state_r == S_XCHK) begin
              ix_r <= idx_r - 9'd1; x0_r <= prev_r; x1_r <= cur;
            end else begin
              iy_r <= idx_r - 9'd1; y0_r <= prev_r; y1_r <= cur;
            end
          end
          prev_r <= cur;
          if (idx_r == hcount - 9'd1) begin
            if (!(found_r || (idx_r > 9'd1 && hit))) begin
              // Clamp: below first sample takes interval 1, else the last.
              if (state_r == S_XCHK) begin
                cx_r <= 1'b1;
                if (qc < ((idx_r == 9'd1) ? cur : h1st_r)) begin
                  ix_r <= 9'd1; x0_r <= h1st_r; x1_r <= h2nd;
                end else begin
                  ix_r <= idx_r - 9'd1; x0_r <= prev_r; x1_r <= cur;
                end
              end else begin
                cy_r <= 1'b1;
                if (qc < h1st_r) begin
                  iy_r <= 9'd1; y0_r <= h1st_r; y1_r <= h2nd;
                end else begin
                  iy_r <= idx_r - 9'd1; y0_r <= prev_r; y1_r <= cur;
                end
              end
            end else if (state_r == S_XCHK) cx_r <= 1'b0;
            else cy_r <= 1'b0;
            idx_r   <= 9'd1;
            found_r <= 1'b0;
            if (state_r == S_XCHK) state_r <= S_YRD;
            else begin
              state_r <= S_CRD;
              csel_r  <= 2'd0;
            end
          end else begin
            idx_r   <= idx_r + 9'd1;
            state_r <= state_nxt;
          end
        end
        S_CRD: state_r <= S_CWAIT;
        S_CWAIT: begin
          unique case (csel_r)
            2'd0: c00_r <= cur;
            2'd1: c01_r <= cur;
            2'd2: c10_r <= cur;
            default: c11_r <= cur;
          endcase
          if (csel_r == 2'd3) begin
            state_r  <= S_DIVX;
            fstart_r <= 1'b1;
            if (x0_r == x1_r || y0_r == y1_r) begin
              res_r   <= '0;
              stat_r  <= STAT_ZERO;
              state_r <= S_DONE;
            end
          end else begin
            csel_r  <= csel_r + 2'd1;
            state_r <= S_CRD;
          end
        end
        S_DIVX: if (fstart_r && wfull) begin
          fx_r <= 33'h1_0000_0000; state_r <= S_DIVY; fstart_r <= 1'b1;
        end else if (div_done) begin
          fx_r <= {1'b0, quot}; state_r <= S_DIVY; fstart_r <= 1'b1;
        end
        S_DIVY: if (fstart_r && wfull) begin
          fy_r <= 33'h1_0000_0000; state_r <= S_MUL1; fstart_r <= 1'b1;
        end else if (div_done) begin
          fy_r <= {1'b0, quot}; state_r <= S_MUL1; fstart_r <= 1'b1;
        end
        S_MUL1: if (mul_done) begin
          r1_r <= lres; state_r <= S_MUL2; fstart_r <= 1'b1;
        end
        S_MUL2: if (mul_done) begin
          r2_r <= lres; state_r <= S_MUL3; fstart_r <= 1'b1;
        end
        S_MUL3: if (mul_done) begin
          if (lres > 34'sh0_7FFF_FFFF)      res_r <= 32'h7FFF_FFFF;
          else if (lres < -34'sh0_8000_0000) res_r <= 32'h8000_0000;
          else                               res_r <= lres[31:0];
          stat_r  <= cx_r ? STAT_XCLMP : (cy_r ? STAT_YCLMP : STAT_OK);
          state_r <= S_DONE;
        end
        S_DONE: state_r <= S_OUT;
        S_OUT:  state_r <= state_nxt;
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid                = (state_r == S_OUT);
  assign out_ch.payload.interp_value = res_r;
  assign out_ch.payload.status       = stat_r;

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !in_ch.ready) else $error("input open during output");
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DONE |=> out_ch.valid) else $error("result not presented");
  a_load_stay: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> state_r == S_IDLE) else $error("load left idle");
endmodule
